/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked while out of reset
`define CHK_RUN(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define CHK_ALL(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/llg_pkg.sv */
`default_nettype none
package llg_pkg;

  typedef struct packed {
    logic signed [31:0] mag_x;
    logic signed [31:0] mag_y;
    logic signed [31:0] mag_z;
  } mag_t;

  typedef struct packed {
    logic signed [31:0] drift_x;
    logic signed [31:0] drift_y;
    logic signed [31:0] drift_z;
    logic signed [31:0] diff_00;
    logic signed [31:0] diff_01;
    logic signed [31:0] diff_02;
    logic signed [31:0] diff_10;
    logic signed [31:0] diff_11;
    logic signed [31:0] diff_12;
    logic signed [31:0] diff_20;
    logic signed [31:0] diff_21;
    logic signed [31:0] diff_22;
  } res_t;

  typedef enum logic [2:0] {
    RegDamping  = 3'd0,
    RegNoise    = 3'd1,
    RegFieldX   = 3'd2,
    RegFieldY   = 3'd3,
    RegFieldZ   = 3'd4,
    RegItoMode  = 3'd5
  } reg_idx_t;

  localparam int AddrW = 5;
  localparam int NumStages = 6;

  localparam logic signed [63:0] QMax = 64'sd2147483647;
  localparam logic signed [63:0] QMin = -64'sd2147483648;

  function automatic logic signed [31:0] sat_q(input logic signed [63:0] v);
    if (v > QMax) return 32'sh7fffffff;
    else if (v < QMin) return 32'sh80000000;
    else return v[31:0];
  endfunction

  // q16.16 product, round half up, saturated
  function automatic logic signed [31:0] fx_mul(input logic signed [31:0] p,
                                                input logic signed [31:0] q);
    logic signed [63:0] pr;
    pr = p * q + 64'sd32768;
    return sat_q(pr >>> 16);
  endfunction

  function automatic logic signed [31:0] fx_neg(input logic signed [31:0] v);
    if (v == 32'sh80000000) return 32'sh7fffffff;
    else return -v;
  endfunction

  function automatic logic signed [31:0] fx_add(input logic signed [31:0] p,
                                                input logic signed [31:0] q);
    return sat_q(64'(p) + 64'(q));
  endfunction

  function automatic logic signed [31:0] fx_sub(input logic signed [31:0] p,
                                                input logic signed [31:0] q);
    return sat_q(64'(p) - 64'(q));
  endfunction

endpackage
`default_nettype wire

/* rtl/llg_stream_if.sv */
`default_nettype none
interface llg_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/llg_drift_diffusion_eval_unit.sv */
`default_nettype none
// channel | direction | payload                          | handshake
// in_ch   | in        | mag_x, mag_y, mag_z              | valid/ready
// out_ch  | out       | drift_x..z, diff_00..diff_22     | valid/ready
// apb     | in        | six config registers, 4*i        | psel/penable
//
// six register stages; a request moves through them in order
// one request per cycle sustained while out_ch is not stalled, each stage has its own valid bit
// a stage advances when empty or when the one after it advances, so
// bubbles close up under an output stall and nothing is dropped
// rst_n is synchronous; it clears valid bits and config registers
module llg_drift_diffusion_eval_unit (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  llg_stream_if.sink                in_ch,
  llg_stream_if.source              out_ch,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [llg_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import llg_pkg::*;

  logic [30:0]        damping_r, noise_r;
  logic signed [31:0] hx_r, hy_r, hz_r;
  logic               ito_r;
  logic signed [31:0] a, s, ns;
  logic signed [31:0] h [3];

  assign pready = 1'b1;
  assign a  = $signed({1'b0, damping_r});
  assign s  = $signed({1'b0, noise_r});
  assign ns = -s;
  assign h[0] = hx_r;
  assign h[1] = hy_r;
  assign h[2] = hz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      damping_r <= '0;
      noise_r   <= '0;
      hx_r      <= '0;
      hy_r      <= '0;
      hz_r      <= '0;
      ito_r     <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx_t'(paddr[4:2]))
        RegDamping: damping_r <= pwdata[30:0];
        RegNoise:   noise_r   <= pwdata[30:0];
        RegFieldX:  hx_r      <= pwdata;
        RegFieldY:  hy_r      <= pwdata;
        RegFieldZ:  hz_r      <= pwdata;
        RegItoMode: ito_r     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[4:2]))
      RegDamping: prdata = {1'b0, damping_r};
      RegNoise:   prdata = {1'b0, noise_r};
      RegFieldX:  prdata = hx_r;
      RegFieldY:  prdata = hy_r;
      RegFieldZ:  prdata = hz_r;
      RegItoMode: prdata = {31'd0, ito_r};
      default:    prdata = '0;
    endcase
  end

  // stage valids and enables
  logic [NumStages:1] v_r;
  logic [NumStages:1] en;

  always_comb begin
    en[NumStages] = !v_r[NumStages] || out_ch.ready;
    for (int k = NumStages - 1; k >= 1; k--) en[k] = !v_r[k] || en[k+1];
  end

  assign in_ch.ready = en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) v_r[1] <= in_ch.valid;
      for (int k = 2; k <= NumStages; k++) if (en[k]) v_r[k] <= v_r[k-1];
    end
  end

  // stage 1: squares, cross products, m*h products, alpha*sigma
  logic signed [31:0] m_in [3];
  logic signed [31:0] m1_r [3], p1_r [6], mh1_r [3][3], as1_r;
  assign m_in[0] = in_ch.data.mag_x;
  assign m_in[1] = in_ch.data.mag_y;
  assign m_in[2] = in_ch.data.mag_z;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        m1_r[i] <= m_in[i];
        for (int j = 0; j < 3; j++) mh1_r[i][j] <= fx_mul(m_in[i], h[j]);
      end
      p1_r[0] <= fx_mul(m_in[0], m_in[0]);
      p1_r[1] <= fx_mul(m_in[1], m_in[1]);
      p1_r[2] <= fx_mul(m_in[2], m_in[2]);
      p1_r[3] <= fx_mul(m_in[0], m_in[1]);
      p1_r[4] <= fx_mul(m_in[0], m_in[2]);
      p1_r[5] <= fx_mul(m_in[1], m_in[2]);
      as1_r   <= fx_mul(a, s);
    end
  end

  // stage 2: sums, precession differences, alpha*p, alpha*sigma*m
  logic signed [31:0] m2_r [3], sq2_r [3], dot2_r [3], ap2_r [3], ak2_r [3], as2_r;
  logic signed [32:0] prec2_r [3];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sq2_r[0]  <= fx_add(p1_r[1], p1_r[2]);
      sq2_r[1]  <= fx_add(p1_r[0], p1_r[2]);
      sq2_r[2]  <= fx_add(p1_r[0], p1_r[1]);
      dot2_r[0] <= fx_add(mh1_r[1][1], mh1_r[2][2]);
      dot2_r[1] <= fx_add(mh1_r[0][0], mh1_r[2][2]);
      dot2_r[2] <= fx_add(mh1_r[0][0], mh1_r[1][1]);
      prec2_r[0] <= 33'(mh1_r[2][1]) - 33'(mh1_r[1][2]);
      prec2_r[1] <= 33'(mh1_r[0][2]) - 33'(mh1_r[2][0]);
      prec2_r[2] <= 33'(mh1_r[1][0]) - 33'(mh1_r[0][1]);
      ap2_r[0]  <= fx_mul(a, p1_r[3]);
      ap2_r[1]  <= fx_mul(a, p1_r[4]);
      ap2_r[2]  <= fx_mul(a, p1_r[5]);
      for (int i = 0; i < 3; i++) begin
        m2_r[i]  <= m1_r[i];
        ak2_r[i] <= fx_mul(as1_r, m1_r[i]);
      end
      as2_r <= as1_r;
    end
  end

  // stage 3: diffusion matrix, damping products, derivative terms
  logic signed [31:0] hs3_r [3], md3_r [3], b3_r [3][3], tk3_r [3], na3_r [3];
  logic signed [32:0] prec3_r [3];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < 3; i++) begin
        hs3_r[i]   <= fx_mul(h[i], sq2_r[i]);
        md3_r[i]   <= fx_mul(m2_r[i], dot2_r[i]);
        b3_r[i][i] <= fx_mul(as2_r, sq2_r[i]);
        tk3_r[i]   <= sat_q(64'(ak2_r[i]) + 64'(ak2_r[i]));
        na3_r[i]   <= fx_neg(ak2_r[i]);
        prec3_r[i] <= prec2_r[i];
      end
      b3_r[0][1] <= fx_mul(s, fx_sub(m2_r[2], ap2_r[0]));
      b3_r[1][0] <= fx_neg(fx_mul(s, fx_add(m2_r[2], ap2_r[0])));
      b3_r[0][2] <= fx_neg(fx_mul(s, fx_add(m2_r[1], ap2_r[1])));
      b3_r[2][0] <= fx_mul(s, fx_sub(m2_r[1], ap2_r[1]));
      b3_r[1][2] <= fx_mul(s, fx_sub(m2_r[0], ap2_r[2]));
      b3_r[2][1] <= fx_neg(fx_mul(s, fx_add(m2_r[0], ap2_r[2])));
    end
  end

  // stage 4: damping term and the ito products
  logic signed [31:0] b4_r [3][3], damp4_r [3], ip4_r [3][8];
  logic signed [32:0] prec4_r [3];
  logic signed [31:0] fb [3][8], fd [3][8];

  always_comb begin
    // drift x
    fb[0][0] = b3_r[1][0]; fd[0][0] = tk3_r[1];
    fb[0][1] = b3_r[2][0]; fd[0][1] = tk3_r[2];
    fb[0][2] = b3_r[0][1]; fd[0][2] = na3_r[1];
    fb[0][3] = b3_r[1][1]; fd[0][3] = na3_r[0];
    fb[0][4] = b3_r[2][1]; fd[0][4] = s;
    fb[0][5] = b3_r[0][2]; fd[0][5] = na3_r[2];
    fb[0][6] = b3_r[1][2]; fd[0][6] = ns;
    fb[0][7] = b3_r[2][2]; fd[0][7] = na3_r[0];
    // drift y
    fb[1][0] = b3_r[0][0]; fd[1][0] = na3_r[1];
    fb[1][1] = b3_r[1][0]; fd[1][1] = na3_r[0];
    fb[1][2] = b3_r[2][0]; fd[1][2] = ns;
    fb[1][3] = b3_r[0][1]; fd[1][3] = tk3_r[0];
    fb[1][4] = b3_r[2][1]; fd[1][4] = tk3_r[2];
    fb[1][5] = b3_r[0][2]; fd[1][5] = s;
    fb[1][6] = b3_r[1][2]; fd[1][6] = na3_r[2];
    fb[1][7] = b3_r[2][2]; fd[1][7] = na3_r[1];
    // drift z
    fb[2][0] = b3_r[0][0]; fd[2][0] = na3_r[2];
    fb[2][1] = b3_r[1][0]; fd[2][1] = s;
    fb[2][2] = b3_r[2][0]; fd[2][2] = na3_r[0];
    fb[2][3] = b3_r[0][1]; fd[2][3] = ns;
    fb[2][4] = b3_r[1][1]; fd[2][4] = na3_r[2];
    fb[2][5] = b3_r[2][1]; fd[2][5] = na3_r[1];
    fb[2][6] = b3_r[0][2]; fd[2][6] = tk3_r[0];
    fb[2][7] = b3_r[1][2]; fd[2][7] = tk3_r[1];
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int i = 0; i < 3; i++) begin
        damp4_r[i] <= fx_mul(a, fx_sub(hs3_r[i], md3_r[i]));
        prec4_r[i] <= prec3_r[i];
        for (int j = 0; j < 3; j++) b4_r[i][j] <= b3_r[i][j];
        for (int t = 0; t < 8; t++) ip4_r[i][t] <= fx_mul(fb[i][t], fd[i][t]);
      end
    end
  end

  // stage 5: precession plus damping, exact ito sums
  logic signed [31:0] b5_r [3][3], d5_r [3];
  logic signed [34:0] isum5_r [3];
  logic signed [34:0] isum [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      isum[i] = '0;
      for (int t = 0; t < 8; t++) isum[i] = isum[i] + 35'(ip4_r[i][t]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int i = 0; i < 3; i++) begin
        d5_r[i]    <= sat_q(64'(prec4_r[i]) + 64'(damp4_r[i]));
        isum5_r[i] <= isum[i];
        for (int j = 0; j < 3; j++) b5_r[i][j] <= b4_r[i][j];
      end
    end
  end

  // stage 6: output register, ito correction added when ito mode is set
  logic signed [31:0] b6_r [3][3], d6_r [3];
  logic signed [34:0] corr [3];

  always_comb begin
    for (int i = 0; i < 3; i++) corr[i] = (isum5_r[i] + 35'sd1) >>> 1;
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int i = 0; i < 3; i++) begin
        d6_r[i] <= ito_r ? sat_q(64'(d5_r[i]) + 64'(corr[i])) : d5_r[i];
        for (int j = 0; j < 3; j++) b6_r[i][j] <= b5_r[i][j];
      end
    end
  end

  assign out_ch.valid        = v_r[NumStages];
  assign out_ch.data.drift_x = d6_r[0];
  assign out_ch.data.drift_y = d6_r[1];
  assign out_ch.data.drift_z = d6_r[2];
  assign out_ch.data.diff_00 = b6_r[0][0];
  assign out_ch.data.diff_01 = b6_r[0][1];
  assign out_ch.data.diff_02 = b6_r[0][2];
  assign out_ch.data.diff_10 = b6_r[1][0];
  assign out_ch.data.diff_11 = b6_r[1][1];
  assign out_ch.data.diff_12 = b6_r[1][2];
  assign out_ch.data.diff_20 = b6_r[2][0];
  assign out_ch.data.diff_21 = b6_r[2][1];
  assign out_ch.data.diff_22 = b6_r[2][2];

endmodule
`default_nettype wire

/* rtl/llg_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module llg_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire llg_pkg::res_t               out_data,
  input wire logic                        psel,
  input wire logic                        penable,
  input wire logic                        pwrite,
  input wire logic [llg_pkg::AddrW-1:0]   paddr,
  input wire logic [31:0]                 pwdata,
  input wire logic [31:0]                 prdata
);
  import llg_pkg::*;

  logic wr;
  assign wr = psel && penable && pwrite;

  `CHK_ALL(a_rst_empty, clk, !rst_n |=> !out_valid, "result shown straight after reset")
  `CHK_RUN(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped")
  `CHK_RUN(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_data), "result changed under stall")
  `CHK_RUN(a_cfg_rb, clk, rst_n, $past(wr) && $past(paddr[4:2]) == RegFieldX && paddr[4:2] == RegFieldX |-> prdata == $past(pwdata), "field readback mismatch")

endmodule

bind llg_drift_diffusion_eval_unit llg_checker u_llg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);
`default_nettype wire
